// ===== src/mpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mpt_pkg;

  localparam int CHANNELS_DEFAULT = 8;

  localparam int INTERVAL_W = 24;
  localparam int RATE_W     = 18;
  localparam int WIDTH_W    = 17;
  localparam int WIDTH_IN_W = 18;
  localparam int PHASE_W    = 24;
  localparam int STEP_W     = 23;
  localparam int PROD_W     = INTERVAL_W + RATE_W;
  localparam int QUO_W      = 22;
  localparam int PULSE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 8;

  localparam int PHASE_ONE = 2 ** (PHASE_W - 1);

  localparam logic [WIDTH_W-1:0]    WIDTH_ONE     = 17'd65536;
  localparam logic [WIDTH_IN_W-1:0] WIDTH_IN_ONE  = 18'd65536;
  localparam logic [PROD_W-1:0]     SHORTEST_PROD = 42'd512000;
  localparam logic [PROD_W-1:0]     REM_INIT      = 42'd512000;
  localparam logic [STEP_W-1:0]     HALF_STEP     = 23'h400000;

  localparam logic [RATE_W-1:0]     SAMPLE_RATE_RST   = 18'd48000;
  localparam logic [INTERVAL_W-1:0] BASE_INTERVAL_RST = 24'd256000;
  localparam logic [WIDTH_W-1:0]    BASE_WIDTH_RST    = 17'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 3'd5;

  typedef struct packed {
    logic                  enabled;
    logic                  use_interval_input;
    logic                  use_width_input;
    logic [INTERVAL_W-1:0] base_interval;
  } mpt_front_cfg_t;

  typedef struct packed {
    logic               load;
    logic [WIDTH_W-1:0] value;
  } mpt_wload_t;

  typedef struct packed {
    logic                  run;
    logic [INTERVAL_W-1:0] interval;
    mpt_wload_t            width;
  } mpt_cmd_t;

endpackage
`default_nettype wire

// ===== src/mpt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpt_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpt_pkg::mpt_front_cfg_t       cfg,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [mpt_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                               q_valid,
  output mpt_pkg::mpt_cmd_t                  q_cmd,
  input  wire logic                          q_pop
);
  import mpt_pkg::*;

  localparam int DEPTH = 2;

  mpt_cmd_t               entry [DEPTH];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  mpt_cmd_t               cmd_in;
  logic [WIDTH_IN_W-1:0]  width_raw;
  logic                   push;
  logic                   pop;

  assign width_raw = s_tdata[INTERVAL_W +: WIDTH_IN_W];

  // Negative widths have the top bit set and so fail the range check.
  always_comb begin
    cmd_in.run         = cfg.enabled;
    cmd_in.interval    = cfg.use_interval_input ? s_tdata[INTERVAL_W-1:0] : cfg.base_interval;
    cmd_in.width.load  = cfg.enabled && cfg.use_width_input && (width_raw <= WIDTH_IN_ONE);
    cmd_in.width.value = width_raw[WIDTH_W-1:0];
  end

  assign s_tready = (count != 2'(DEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = entry[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif
endmodule
`default_nettype wire

// ===== src/mpt_step_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpt_step_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [mpt_pkg::INTERVAL_W-1:0] interval,
  input  wire logic [mpt_pkg::RATE_W-1:0]     sample_rate,
  output logic                                done,
  output logic [mpt_pkg::STEP_W-1:0]          step
);
  import mpt_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_CHK, D_DIV} dstate_t;

  dstate_t               state;
  logic [INTERVAL_W-1:0] op_a;
  logic [RATE_W-1:0]     op_b;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     rem;
  logic [QUO_W-1:0]      quo;
  logic [4:0]            cnt;
  logic [PROD_W:0]       shifted;
  logic [PROD_W:0]       trial;
  logic                  qbit;
  logic [QUO_W-1:0]      quo_next;

  // The numerator is 256000 * 2^23: its low 22 bits are zero, so the
  // remainder starts at its top bits and shifts in zeros.
  always_comb begin
    shifted  = {rem, 1'b0};
    trial    = shifted - {1'b0, prod};
    qbit     = (shifted >= {1'b0, prod});
    quo_next = {quo[QUO_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= 5'd0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            op_a  <= interval;
            op_b  <= sample_rate;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          prod  <= {{RATE_W{1'b0}}, op_a} * {{INTERVAL_W{1'b0}}, op_b};
          state <= D_CHK;
        end
        D_CHK: begin
          if (prod <= SHORTEST_PROD) begin
            step  <= HALF_STEP;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            rem   <= REM_INIT;
            quo   <= '0;
            cnt   <= 5'd0;
            state <= D_DIV;
          end
        end
        D_DIV: begin
          rem <= qbit ? trial[PROD_W-1:0] : shifted[PROD_W-1:0];
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QUO_W - 1)) begin
            step  <= {1'b0, quo_next};
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> step <= HALF_STEP)
    else $error("step above one half");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == D_DIV |-> rem < prod)
    else $error("divider remainder not below divisor");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == D_DIV |-> cnt < 5'(QUO_W))
    else $error("divider step count overrun");
`endif
endmodule
`default_nettype wire

// ===== src/mpt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpt_back #(
  parameter int CHANNELS = mpt_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpt_pkg::mpt_wload_t           cfg_wload,
  input  wire logic                          q_valid,
  input  wire mpt_pkg::mpt_cmd_t             q_cmd,
  output logic                               q_pop,
  output logic                               div_start,
  output logic [mpt_pkg::INTERVAL_W-1:0]     div_interval,
  input  wire logic                          div_done,
  input  wire logic [mpt_pkg::STEP_W-1:0]    div_step,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mpt_pkg::M_TDATA_W-1:0]      m_tdata
);
  import mpt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_APPLY} bstate_t;

  bstate_t            state;
  logic               cmd_run;
  logic [STEP_W-1:0]  step;
  logic [WIDTH_W-1:0] current_width;
  logic [PHASE_W-1:0] limit;
  logic [PHASE_W-1:0] phase      [CHANNELS];
  logic [PHASE_W-1:0] phase_next [CHANNELS];
  logic [PULSE_W-1:0] hit;
  logic               out_free;
  logic               advance;

  assign q_pop        = (state == ST_IDLE) && q_valid;
  assign div_start    = q_pop && q_cmd.run;
  assign div_interval = q_cmd.interval;
  assign out_free     = !m_tvalid || m_tready;
  assign advance      = (state == ST_APPLY) && out_free && cmd_run;
  assign limit        = {current_width, 7'b0};

  for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
    localparam int INIT = PHASE_ONE + (n * PHASE_ONE) / CHANNELS;
    logic [PHASE_W:0] diff;

    // A phase that would go below zero wraps up by one.
    always_comb begin
      diff          = {1'b0, phase[n]} - {2'b0, step};
      phase_next[n] = diff[PHASE_W] ? diff[PHASE_W-1:0] + PHASE_W'(PHASE_ONE)
                                    : diff[PHASE_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        phase[n] <= PHASE_W'(INIT);
      end else if (advance) begin
        phase[n] <= phase_next[n];
      end
    end
  end

  for (genvar n = 0; n < PULSE_W; n++) begin : g_hit
    if (n < CHANNELS) begin : g_on
      assign hit[n] = (phase[n] <= limit);
    end else begin : g_off
      assign hit[n] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cmd_run       <= 1'b0;
      current_width <= BASE_WIDTH_RST;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wload.load) begin
        current_width <= cfg_wload.value;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd_run <= q_cmd.run;
            if (q_cmd.width.load) begin
              current_width <= q_cmd.width.value;
            end
            state <= q_cmd.run ? ST_WAIT : ST_APPLY;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            step  <= div_step;
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= cmd_run ? M_TDATA_W'(hit) : '0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    current_width <= WIDTH_ONE)
    else $error("current width above one");
  a_wait_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> cmd_run)
    else $error("waiting on divider while disabled");
  a_idle_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && out_free && !cmd_run) |=> m_tvalid && m_tdata == '0)
    else $error("disabled beat not zero");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_WAIT)
    else $error("step arrived outside wait");
`endif
endmodule
`default_nettype wire

// ===== src/multiphase_pulse_train_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Multiphase pulse train generator. Each input beat is one sample tick and
// yields one output beat whose bit n is the level of channel n; all channels
// share one period and duty ratio and are spread evenly in phase. Input beats
// go into a two-entry queue, so the input side keeps accepting while the back
// end works, until both entries are full. With the block enabled a tick
// passes through the 24 x 18 multiply and the 22-step restoring divider that
// derives the phase step from the interval and sample rate; a tick whose
// interval is clamped to the shortest one skips the divider, and while
// disabled a tick skips both. A stalled output holds the back end. Registers
// are written by index on the configuration port and should be changed only
// while no tick is in flight.
module multiphase_pulse_train_core #(
  parameter int CHANNELS = mpt_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0: interval_sample[23:0], width_sample[41:24], zero pad.
  input  wire logic [mpt_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // Fields from bit 0: pulses[7:0].
  output logic [mpt_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [mpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mpt_pkg::*;

  logic [RATE_W-1:0]     sample_rate;
  logic [INTERVAL_W-1:0] base_interval;
  logic                  use_interval_input;
  logic                  use_width_input;
  logic                  enabled;

  mpt_front_cfg_t        front_cfg;
  mpt_wload_t            cfg_wload;
  logic                  q_valid;
  mpt_cmd_t              q_cmd;
  logic                  q_pop;
  logic                  div_start;
  logic [INTERVAL_W-1:0] div_interval;
  logic                  div_done;
  logic [STEP_W-1:0]     div_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate        <= SAMPLE_RATE_RST;
      base_interval      <= BASE_INTERVAL_RST;
      use_interval_input <= 1'b0;
      use_width_input    <= 1'b0;
      enabled            <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE:   sample_rate        <= cfg_data[RATE_W-1:0];
        REG_BASE_INTERVAL: base_interval      <= cfg_data[INTERVAL_W-1:0];
        REG_USE_INTERVAL:  use_interval_input <= cfg_data[0];
        REG_USE_WIDTH:     use_width_input    <= cfg_data[0];
        REG_ENABLED:       enabled            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A base width write in range also becomes the working width.
  always_comb begin
    cfg_wload.load  = cfg_we && (cfg_index == REG_BASE_WIDTH)
                      && (cfg_data[WIDTH_W-1:0] <= WIDTH_ONE);
    cfg_wload.value = cfg_data[WIDTH_W-1:0];
  end

  always_comb begin
    front_cfg.enabled            = enabled;
    front_cfg.use_interval_input = use_interval_input;
    front_cfg.use_width_input    = use_width_input;
    front_cfg.base_interval      = base_interval;
  end

  mpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (front_cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  mpt_step_div u_step_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .interval    (div_interval),
    .sample_rate (sample_rate),
    .done        (div_done),
    .step        (div_step)
  );

  mpt_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wload    (cfg_wload),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_interval (div_interval),
    .div_done     (div_done),
    .div_step     (div_step),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule
`default_nettype wire
